### rtl/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg: shared types and constants for the I2C EEPROM byte access master
// Payload structs for both channels, action codes and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

  localparam int WAIT_COUNT_BITS_DEF = 20;
  localparam int CFG_WAIT_BITS       = 20;
  localparam logic [CFG_WAIT_BITS-1:0] WAIT_TICKS_RESET = 20'd10000;

  // low bit of the device address byte selects a read
  localparam logic [7:0] READ_BIT = 8'h01;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] device_address;
    logic [7:0] word_address;
    logic [7:0] write_data;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } out_t;

endpackage

`default_nettype wire

### rtl/i2cee_core.sv
// ----------------------------------------------------------------------------
// i2cee_core: I2C pin sequencer state and one-tick step logic
// Holds the sequencer state; computes the pin levels for the tick in hand and
// updates the state when step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_core #(
  parameter int WAIT_COUNT_BITS = i2cee_pkg::WAIT_COUNT_BITS_DEF
) (
  input  wire                                        clk,
  input  wire                                        rst,
  input  wire                                        step,
  input  i2cee_pkg::in_t                             item,
  input  wire [i2cee_pkg::CFG_WAIT_BITS-1:0]         wait_ticks,
  output i2cee_pkg::out_t                            result
);
  import i2cee_pkg::*;

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_START_A = 5'd1;
  localparam logic [4:0] PH_DEV_W   = 5'd2;
  localparam logic [4:0] PH_ACK_A   = 5'd3;
  localparam logic [4:0] PH_WORD    = 5'd4;
  localparam logic [4:0] PH_ACK_B   = 5'd5;
  localparam logic [4:0] PH_DATA    = 5'd6;
  localparam logic [4:0] PH_ACK_C   = 5'd7;
  localparam logic [4:0] PH_START_B = 5'd8;
  localparam logic [4:0] PH_DEV_R   = 5'd9;
  localparam logic [4:0] PH_ACK_D   = 5'd10;
  localparam logic [4:0] PH_READ    = 5'd11;
  localparam logic [4:0] PH_NOACK   = 5'd12;
  localparam logic [4:0] PH_STOP    = 5'd13;
  localparam logic [4:0] PH_WAIT    = 5'd14;

  logic [4:0]                 phase, phase_next;
  logic [2:0]                 bit_position, bit_position_next;
  logic [1:0]                 sub_step, sub_step_next;
  logic [7:0]                 read_byte, read_byte_next;
  logic [7:0]                 held_device_address, held_device_address_next;
  logic [7:0]                 held_word_address, held_word_address_next;
  logic [7:0]                 held_write_data, held_write_data_next;
  logic                       is_read_request, is_read_request_next;
  logic [WAIT_COUNT_BITS-1:0] wait_counter, wait_counter_next;
  logic                       clock_level, clock_level_next;
  logic                       data_level, data_level_next;
  logic                       done;
  logic [7:0]                 tx_byte;
  logic [4:0]                 phase_after;

  // phase that follows the current one
  always_comb begin
    unique case (phase)
      PH_START_A: phase_after = PH_DEV_W;
      PH_DEV_W:   phase_after = PH_ACK_A;
      PH_ACK_A:   phase_after = PH_WORD;
      PH_WORD:    phase_after = PH_ACK_B;
      PH_ACK_B:   phase_after = is_read_request ? PH_START_B : PH_DATA;
      PH_DATA:    phase_after = PH_ACK_C;
      PH_ACK_C:   phase_after = PH_STOP;
      PH_START_B: phase_after = PH_DEV_R;
      PH_DEV_R:   phase_after = PH_ACK_D;
      PH_ACK_D:   phase_after = PH_READ;
      PH_READ:    phase_after = PH_NOACK;
      PH_NOACK:   phase_after = PH_STOP;
      default:    phase_after = PH_IDLE;
    endcase
  end

  always_comb begin
    unique case (phase)
      PH_DEV_W: tx_byte = held_device_address;
      PH_WORD:  tx_byte = held_word_address;
      PH_DATA:  tx_byte = held_write_data;
      default:  tx_byte = held_device_address | READ_BIT;
    endcase
  end

  always_comb begin
    phase_next               = phase;
    bit_position_next        = bit_position;
    sub_step_next            = sub_step;
    read_byte_next           = read_byte;
    held_device_address_next = held_device_address;
    held_word_address_next   = held_word_address;
    held_write_data_next     = held_write_data;
    is_read_request_next     = is_read_request;
    wait_counter_next        = wait_counter;
    clock_level_next         = clock_level;
    data_level_next          = data_level;
    done                     = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (item.action == ACT_WRITE || item.action == ACT_READ) begin
          held_device_address_next = item.device_address;
          held_word_address_next   = item.word_address;
          held_write_data_next     = item.write_data;
          is_read_request_next     = (item.action == ACT_READ);
          if (item.action == ACT_READ) begin
            read_byte_next = 8'h00;
          end
          // first start step happens on the request tick
          phase_next        = PH_START_A;
          bit_position_next = 3'd7;
          clock_level_next  = 1'b0;
          sub_step_next     = 2'd1;
        end
      end
      PH_WAIT: begin
        if (wait_counter != '0) begin
          wait_counter_next = wait_counter - 1'b1;
        end else begin
          done              = 1'b1;
          phase_next        = PH_IDLE;
          sub_step_next     = 2'd0;
          bit_position_next = 3'd7;
        end
      end
      PH_START_A, PH_START_B: begin
        case (sub_step)
          2'd0: clock_level_next = 1'b0;
          2'd1: data_level_next  = 1'b1;
          2'd2: clock_level_next = 1'b1;
          default: data_level_next = 1'b0;
        endcase
        if (sub_step == 2'd3) begin
          phase_next        = phase_after;
          sub_step_next     = 2'd0;
          bit_position_next = 3'd7;
        end else begin
          sub_step_next = sub_step + 2'd1;
        end
      end
      PH_DEV_W, PH_WORD, PH_DATA, PH_DEV_R: begin
        case (sub_step)
          2'd0: begin
            clock_level_next = 1'b0;
            sub_step_next    = 2'd1;
          end
          2'd1: begin
            data_level_next = tx_byte[bit_position];
            sub_step_next   = 2'd2;
          end
          default: begin
            clock_level_next = 1'b1;
            sub_step_next    = 2'd0;
            if (bit_position == 3'd0) begin
              phase_next        = phase_after;
              bit_position_next = 3'd7;
            end else begin
              bit_position_next = bit_position - 3'd1;
            end
          end
        endcase
      end
      PH_ACK_A, PH_ACK_B, PH_ACK_C, PH_ACK_D: begin
        case (sub_step)
          2'd0: begin
            clock_level_next = 1'b0;
            sub_step_next    = 2'd1;
          end
          2'd1: begin
            data_level_next = 1'b1;
            sub_step_next   = 2'd2;
          end
          2'd2: begin
            clock_level_next = 1'b1;
            sub_step_next    = 2'd3;
          end
          default: begin
            // wait here for the slave to pull data low, no timeout
            if (!item.sda_in) begin
              phase_next        = phase_after;
              sub_step_next     = 2'd0;
              bit_position_next = 3'd7;
            end
          end
        endcase
      end
      PH_READ: begin
        case (sub_step)
          2'd0: begin
            clock_level_next = 1'b0;
            sub_step_next    = 2'd1;
          end
          2'd1: begin
            clock_level_next = 1'b1;
            sub_step_next    = 2'd2;
          end
          default: begin
            if (item.sda_in) begin
              read_byte_next[bit_position] = 1'b1;
            end
            sub_step_next = 2'd0;
            if (bit_position == 3'd0) begin
              phase_next        = phase_after;
              bit_position_next = 3'd7;
            end else begin
              bit_position_next = bit_position - 3'd1;
            end
          end
        endcase
      end
      PH_NOACK: begin
        case (sub_step)
          2'd0: begin
            clock_level_next = 1'b0;
            sub_step_next    = 2'd1;
          end
          2'd1: begin
            data_level_next = 1'b1;
            sub_step_next   = 2'd2;
          end
          default: begin
            clock_level_next  = 1'b1;
            phase_next        = phase_after;
            sub_step_next     = 2'd0;
            bit_position_next = 3'd7;
          end
        endcase
      end
      PH_STOP: begin
        case (sub_step)
          2'd0: clock_level_next = 1'b0;
          2'd1: data_level_next  = 1'b0;
          2'd2: clock_level_next = 1'b1;
          default: data_level_next = 1'b1;
        endcase
        if (sub_step == 2'd3) begin
          phase_next        = PH_WAIT;
          sub_step_next     = 2'd0;
          bit_position_next = 3'd7;
          wait_counter_next = WAIT_COUNT_BITS'(wait_ticks);
        end else begin
          sub_step_next = sub_step + 2'd1;
        end
      end
      default: begin
        phase_next        = PH_IDLE;
        sub_step_next     = 2'd0;
        bit_position_next = 3'd7;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_IDLE;
      bit_position        <= 3'd7;
      sub_step            <= 2'd0;
      read_byte           <= 8'h00;
      held_device_address <= 8'h00;
      held_word_address   <= 8'h00;
      held_write_data     <= 8'h00;
      is_read_request     <= 1'b0;
      wait_counter        <= '0;
      clock_level         <= 1'b1;
      data_level          <= 1'b1;
    end else if (step) begin
      phase               <= phase_next;
      bit_position        <= bit_position_next;
      sub_step            <= sub_step_next;
      read_byte           <= read_byte_next;
      held_device_address <= held_device_address_next;
      held_word_address   <= held_word_address_next;
      held_write_data     <= held_write_data_next;
      is_read_request     <= is_read_request_next;
      wait_counter        <= wait_counter_next;
      clock_level         <= clock_level_next;
      data_level          <= data_level_next;
    end
  end

  assign result.scl_out   = clock_level_next;
  assign result.sda_out   = data_level_next;
  assign result.busy_res  = (phase_next != PH_IDLE);
  assign result.done_res  = done;
  assign result.read_data = read_byte_next;

endmodule

`default_nettype wire

### rtl/i2c_master_eeprom_byte_access_top.sv
// ----------------------------------------------------------------------------
// i2c_master_eeprom_byte_access_top: tick-driven I2C master for EEPROM bytes
// Byte write and random byte read to a serial EEPROM, one line change or one
// data line sample per tick, with a programmable busy wait after each stop.
// ----------------------------------------------------------------------------
//   channel | handshake                | payload
//   --------+--------------------------+------------------------------------
//   input   | in_valid / in_stall      | in_data  (action, addresses, data, sda)
//   output  | out_valid / out_stall    | out_data (scl, sda, busy, done, byte)
//   config  | cfg_wr_en                | cfg_wr_data (post-stop wait ticks)
//
// Each tick passes through an input register, the one-tick step logic of the
// sequencer, and an output register, so a transfer on the input can happen
// every cycle while the output is not stalled.
// rst (synchronous) returns the sequencer to idle with both lines released
// and the wait register to 10000. A stall on the output holds the result and,
// once the input register is also full, raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_eeprom_byte_access_top #(
  parameter int WAIT_COUNT_BITS = i2cee_pkg::WAIT_COUNT_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_wr_en,
  input  wire [i2cee_pkg::CFG_WAIT_BITS-1:0] cfg_wr_data,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  i2cee_pkg::in_t                     in_data,
  output logic                               out_valid,
  input  wire                                out_stall,
  output i2cee_pkg::out_t                    out_data
);
  import i2cee_pkg::*;

  logic [CFG_WAIT_BITS-1:0] post_stop_wait_ticks;

  // input register
  logic in_full;
  in_t  in_q;

  // tick moves from the input register to the output register
  logic move;
  out_t step_result;

  assign move     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !move;

  // wait length register; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      post_stop_wait_ticks <= WAIT_TICKS_RESET;
    end else if (cfg_wr_en) begin
      post_stop_wait_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  // sequencer state advances exactly once per tick that moves on
  i2cee_core #(
    .WAIT_COUNT_BITS(WAIT_COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (move),
    .item      (in_q),
    .wait_ticks(post_stop_wait_ticks),
    .result    (step_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data <= step_result;
    end
  end

endmodule

`default_nettype wire

### rtl/i2cee_checker.sv
// ----------------------------------------------------------------------------
// i2cee_checker: port-level checks for the I2C EEPROM byte access master
// Watches the top-level ports; attached by the bind at the end of this file.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                cfg_wr_en,
  input wire [i2cee_pkg::CFG_WAIT_BITS-1:0] cfg_wr_data,
  input wire                                in_valid,
  input wire                                in_stall,
  input i2cee_pkg::in_t                     in_data,
  input wire                                out_valid,
  input wire                                out_stall,
  input i2cee_pkg::out_t                    out_data
);
  import i2cee_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // input backs up only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // finishing tick is never busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done while busy");

  // when not busy both lines are released
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.busy_res |-> out_data.scl_out && out_data.sda_out)
    else $error("line held low while idle");

endmodule

bind i2c_master_eeprom_byte_access_top i2cee_checker u_checker (.*);

`default_nettype wire
